@@ rtl/stbs_pkg.sv @@
// ============================================================================
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ============================================================================
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int LEN_W   = 7;
    localparam int INDEX_W = 6;
    localparam int DATA_W  = 32;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [DATA_W-1:0]  entry_value;
        logic signed [DATA_W-1:0]  search_key;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/stbs_table_mem.sv @@
// ============================================================================
// stbs_table_mem
// Table storage: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module stbs_table_mem #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire                             clk,
    input  wire                             wr_en,
    input  wire  [AW-1:0]                   wr_addr,
    input  wire  signed [stbs_pkg::DATA_W-1:0] wr_data,
    input  wire                             rd_en,
    input  wire  [AW-1:0]                   rd_addr,
    output logic signed [stbs_pkg::DATA_W-1:0] rd_data
);

    logic signed [stbs_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
    logic signed [stbs_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/stbs_search_ctrl.sv @@
// ============================================================================
// stbs_search_ctrl
// Input decode and binary search sequencer driving the table memory.
// ============================================================================
`default_nettype none

module stbs_search_ctrl #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  stbs_pkg::in_item_t         in_item,
    input  wire  [stbs_pkg::LEN_W-1:0]       table_length,
    output logic                             mem_wr_en,
    output logic [AW-1:0]                    mem_wr_addr,
    output logic signed [stbs_pkg::DATA_W-1:0] mem_wr_data,
    output logic                             mem_rd_en,
    output logic [AW-1:0]                    mem_rd_addr,
    input  wire  signed [stbs_pkg::DATA_W-1:0] mem_rd_data,
    output logic                             res_valid,
    output stbs_pkg::out_item_t              res_item,
    input  wire                              res_free
);

    // bounds run over 0..len, hp1 is high + 1
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                         state_reg,  state_next;
    logic [CW-1:0]                      low_reg,    low_next;
    logic [CW-1:0]                      hp1_reg,    hp1_next;
    logic [AW-1:0]                      mid_reg,    mid_next;
    logic signed [stbs_pkg::DATA_W-1:0] key_reg,    key_next;
    logic                               found_reg,  found_next;
    logic [stbs_pkg::INDEX_W-1:0]       pos_reg,    pos_next;

    logic          accept;
    logic [CW-1:0] len_capped;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_calc;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (int'(table_length) > TABLE_DEPTH)
        begin
            len_capped = CW'(TABLE_DEPTH);
        end
        else
        begin
            len_capped = CW'(table_length);
        end
    end

    // floor((low + high) / 2) with high = hp1 - 1; only used while low < hp1
    assign mid_sum  = {1'b0, low_reg} + {1'b0, hp1_reg} - (CW+1)'(1);
    assign mid_calc = AW'(mid_sum >> 1);

    assign mem_wr_en   = accept && (in_item.kind == stbs_pkg::KIND_WRITE)
                         && (int'(in_item.entry_index) < TABLE_DEPTH);
    assign mem_wr_addr = AW'(in_item.entry_index);
    assign mem_wr_data = in_item.entry_value;

    assign mem_rd_en   = (state_reg == ST_PROBE) && (low_reg < hp1_reg);
    assign mem_rd_addr = mid_calc;

    assign res_valid         = (state_reg == ST_DONE);
    assign res_item.found    = found_reg;
    assign res_item.position = pos_reg;

    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        hp1_next   = hp1_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_item.kind == stbs_pkg::KIND_SEARCH))
                begin
                    key_next   = in_item.search_key;
                    low_next   = '0;
                    hp1_next   = len_capped;
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (low_reg < hp1_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if (key_reg > mem_rd_data)
                begin
                    low_next   = CW'(mid_reg) + CW'(1);
                    state_next = ST_PROBE;
                end
                else if (key_reg < mem_rd_data)
                begin
                    hp1_next   = CW'(mid_reg);
                    state_next = ST_PROBE;
                end
                else
                begin
                    found_next = 1'b1;
                    pos_next   = stbs_pkg::INDEX_W'(mid_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        hp1_reg   <= hp1_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

`ifndef SYNTHESIS
    a_read_then_compare: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |=> (state_reg == ST_CMP))
        else $error("table read not followed by compare");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE || state_reg == ST_CMP) |-> (low_reg <= hp1_reg))
        else $error("search bounds crossed past each other");

    a_write_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (in_valid && state_reg == ST_IDLE))
        else $error("table written without an accepted transaction");

    a_notfound_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_item.found) |-> (res_item.position == '0))
        else $error("not-found result carries a nonzero position");
`endif

endmodule

`default_nettype wire

@@ rtl/sorted_table_binary_search.sv @@
// ============================================================================
// sorted_table_binary_search
// Binary search over a loaded table of signed 32-bit entries.
// ============================================================================
// Usage:
//   in channel (in_valid/in_ready/in_item): kind selects a table write or a
//   search. A write stores entry_value at entry_index and gives
//   no result; indexes at or above TABLE_DEPTH are dropped. A search looks
//   for search_key over the first table_length entries (capped at
//   TABLE_DEPTH) and returns one transaction on the out channel with found
//   and position (0 when not found).
//   cfg_we/cfg_wdata write table_length; write it only while idle.
//   Each probe is a memory read then a compare; a search makes P
//   probes (P <= clog2(len)+1, 7 for 64 entries) and ends from a compare on a
//   hit or from a further probe step on a miss; the next transaction is taken
//   once the result is handed off. Writes go back to back, one per cycle,
//   while no search is in progress.
//   The result sits in an output register; the sequencer keeps accepting
//   transactions while it waits, and only holds a finished search if a
//   previous result is still not taken.
//   Reset clears table_length and all control state; table contents are
//   undefined until written.
// ============================================================================
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  stbs_pkg::in_item_t     in_item,
    output logic                         out_valid,
    input  wire                          out_ready,
    output stbs_pkg::out_item_t          out_item,
    input  wire                          cfg_we,
    input  wire  [stbs_pkg::LEN_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [stbs_pkg::LEN_W-1:0]         table_length_reg;
    logic                               out_valid_reg, out_valid_next;
    stbs_pkg::out_item_t                out_item_reg;

    logic                               mem_wr_en;
    logic [AW-1:0]                      mem_wr_addr;
    logic signed [stbs_pkg::DATA_W-1:0] mem_wr_data;
    logic                               mem_rd_en;
    logic [AW-1:0]                      mem_rd_addr;
    logic signed [stbs_pkg::DATA_W-1:0] mem_rd_data;
    logic                               res_valid;
    stbs_pkg::out_item_t                res_item;
    logic                               res_free;

    assign res_free = !out_valid_reg || out_ready;

    stbs_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_item      (in_item),
        .table_length (table_length_reg),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .res_valid    (res_valid),
        .res_item     (res_item),
        .res_free     (res_free)
    );

    stbs_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_length_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_free)
        begin
            out_item_reg <= res_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_free) |=> (out_valid && out_item == $past(res_item)))
        else $error("finished search not loaded into output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_item))
        else $error("pending result overwritten");

    a_busy_while_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("new transaction accepted before search result handed off");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench for sorted_table_binary_search: loads tables over the input
// channel, runs key lookups and checks every search transaction against a
// local binary-search predictor, with random gaps and stalls on both sides.
// ============================================================================

module tb;

    localparam int TABLE_DEPTH  = stbs_pkg::TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 750;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    stbs_pkg::in_item_t            in_item;
    logic                          out_valid;
    logic                          out_ready;
    stbs_pkg::out_item_t           out_item;
    logic                          cfg_we;
    logic [stbs_pkg::LEN_W-1:0]    cfg_wdata;

    // local copy of the block state
    logic signed [stbs_pkg::DATA_W-1:0] table_image [TABLE_DEPTH];
    logic [stbs_pkg::LEN_W-1:0]         length_image = '0;

    stbs_pkg::out_item_t pending_results [$];
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    bit                  no_gaps        = 1'b0;

    sorted_table_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic stbs_pkg::out_item_t lookup_key(
        input logic signed [stbs_pkg::DATA_W-1:0] key);
        stbs_pkg::out_item_t r;
        int                  lo;
        int                  hi;
        int                  mid;
        int                  n;
        bit                  hit;
        r   = '0;
        hit = 1'b0;
        n   = (int'(length_image) > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_image);
        lo  = 0;
        hi  = n - 1;
        while (!hit && lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key > table_image[mid])
                lo = mid + 1;
            else if (key < table_image[mid])
                hi = mid - 1;
            else
            begin
                hit        = 1'b1;
                r.found    = 1'b1;
                r.position = mid[stbs_pkg::INDEX_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic stbs_pkg::in_item_t make_write(input int idx, input int val);
        stbs_pkg::in_item_t t;
        t.kind        = stbs_pkg::KIND_WRITE;
        t.entry_index = idx[stbs_pkg::INDEX_W-1:0];
        t.entry_value = val;
        t.search_key  = $urandom;
        return t;
    endfunction

    function automatic stbs_pkg::in_item_t make_search(
        input logic signed [stbs_pkg::DATA_W-1:0] key);
        stbs_pkg::in_item_t t;
        int                 filler_idx;
        filler_idx    = $urandom_range(0, TABLE_DEPTH - 1);
        t.kind        = stbs_pkg::KIND_SEARCH;
        t.entry_index = filler_idx[stbs_pkg::INDEX_W-1:0];
        t.entry_value = $urandom;
        t.search_key  = key;
        return t;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_transaction(input stbs_pkg::in_item_t t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (t.kind == stbs_pkg::KIND_WRITE)
            table_image[t.entry_index] = t.entry_value;
        else
            pending_results.push_back(lookup_key(t.search_key));
    endtask

    // Writes give no result, so hold off a little after the last search drains.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input int len);
        cfg_we    <= 1'b1;
        cfg_wdata <= len[stbs_pkg::LEN_W-1:0];
        @(posedge clk);
        cfg_we       <= 1'b0;
        length_image  = len[stbs_pkg::LEN_W-1:0];
    endtask

    task automatic test_empty_table();
        // length is zero out of reset: no entry is probed
        send_transaction(make_search(32'sd0));
        send_transaction(make_search(32'sh80000000));
        send_transaction(make_search(32'sh7fffffff));
    endtask

    task automatic test_extreme_values();
        int extreme_vals [5];
        int i;
        extreme_vals = '{32'sh80000000, -1, 0, 1, 32'sh7fffffff};
        wait_for_idle();
        write_length(5);
        for (i = 0; i < 5; i++)
            send_transaction(make_write(i, extreme_vals[i]));
        for (i = 0; i < 5; i++)
            send_transaction(make_search(extreme_vals[i]));
        send_transaction(make_search(-32'sd2));
        send_transaction(make_search(32'sh7ffffffe));
    endtask

    task automatic test_single_entry();
        wait_for_idle();
        write_length(1);
        send_transaction(make_search(32'sh80000000));
        send_transaction(make_search(32'sd0));
    endtask

    task automatic test_unsorted_table();
        wait_for_idle();
        write_length(3);
        send_transaction(make_write(0, 5));
        send_transaction(make_write(1, -7));
        send_transaction(make_write(2, 3));
        send_transaction(make_search(-32'sd7));
        send_transaction(make_search(32'sd5));
        send_transaction(make_search(32'sd3));
    endtask

    // Load the first entries in random order, then mostly hit or near-miss keys.
    task automatic run_search_phase(input int len, output int count);
        int                                 n;
        int                                 style;
        int                                 i;
        int                                 j;
        int                                 tmp;
        int                                 searches;
        int                                 pick;
        int                                 vals [$];
        int                                 order [$];
        logic signed [stbs_pkg::DATA_W-1:0] key;
        n     = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
        style = $urandom_range(0, 9);
        for (i = 0; i < n; i++)
        begin
            if (style >= 6 && style < 9)
                vals.push_back($urandom_range(0, 12) - 6);  // narrow: duplicates
            else
                vals.push_back($urandom);
            order.push_back(i);
        end
        if (style < 9)
            vals.sort();
        for (i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < n; i++)
            send_transaction(make_write(order[i], vals[order[i]]));
        searches = $urandom_range(8, 30);
        for (i = 0; i < searches; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // stray overwrite, may break the ordering
                j   = $urandom_range(0, TABLE_DEPTH - 1);
                tmp = $urandom;
                if (j < n)
                    vals[j] = tmp;
                send_transaction(make_write(j, tmp));
            end
            else
            begin
                if (n == 0 || pick >= 17)
                    key = $urandom;
                else if (pick == 16)
                    key = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                else if (pick >= 13)
                    key = vals[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
                else
                    key = vals[$urandom_range(0, n - 1)];
                send_transaction(make_search(key));
            end
        end
        count = n + searches;
    endtask

    task automatic test_random_phases();
        int phase;
        int len;
        int sent;
        int count;
        int r;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            case (phase)
                0: len = 64;
                1: len = 127;
                2: len = 0;
                default:
                begin
                    if (r < 6)
                        len = $urandom_range(1, 16);
                    else if (r < 8)
                        len = $urandom_range(17, 63);
                    else if (r < 9)
                        len = $urandom_range(64, 127);
                    else
                        len = $urandom_range(0, 1) ? 64 : 0;
                end
            endcase
            wait_for_idle();
            no_gaps = ($urandom_range(0, 3) == 0);
            write_length(len);
            run_search_phase(len, count);
            sent  += count;
            phase += 1;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin : result_checker
        int                  stall;
        stbs_pkg::out_item_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual found=%0b pos=%0d",
                         $time, out_item.found, out_item.position);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.found !== want.found)
                begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, out_item.found);
                    mismatch_count++;
                end
                if (out_item.position !== want.position)
                begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.position, out_item.position);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_extreme_values();
        test_single_entry();
        test_unsorted_table();
        test_random_phases();
        wait_for_idle();
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/stbs_pkg.sv
rtl/stbs_table_mem.sv
rtl/stbs_search_ctrl.sv
rtl/sorted_table_binary_search.sv
tb/sv/tb.sv
